/* sv/drt_pkg.sv */
// Shared types and constants for the dirty rectangle tracker.
`default_nettype none

package drt_pkg;

  localparam int MAX_RECTS_DEF = 128;
  localparam int SCREEN_LIMIT  = 4096;

  localparam logic [12:0] SCREEN_W_RST = 13'd640;
  localparam logic [12:0] SCREEN_H_RST = 13'd480;

  // Configuration register indexes
  localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

  // Mark outcome codes
  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    KIND_MARK  = 3'd0,
    KIND_QUERY = 3'd1,
    KIND_FULL  = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_QUERY,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

/* sv/dirty_rect_tracker.sv */
// Dirty rectangle tracker: rectangle table in one single-port memory plus full-dirty flag.
// An accepted beat passes the exec and emit states before out_tvalid rises for mark, read,
// clear, mark-full and unused kinds; a query also walks the table one entry per cycle through
// the single memory port between those states. A new beat is taken only once the result sits
// in the output register, so one beat is handled at a time.
// Reset: full-dirty set, count zero, screen 640 x 480; table contents stay undefined.
`default_nettype none

module dirty_rect_tracker #(
  parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], entry_index[71:64]
  input  wire logic [71:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], needs_redraw[2], full_dirty[3], has_dirty[4], dirty_count[12:5],
  // entry_x[24:13], entry_y[36:25], entry_w[49:37], entry_h[62:50], zero[63]
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RECTS);
  localparam logic [12:0] LIMIT_C = 13'(drt_pkg::SCREEN_LIMIT);

  drt_pkg::state_t state_r, state_nxt;
  drt_pkg::kind_t  kind_r;

  logic signed [15:0] rect_x_r, rect_y_r, rect_w_r, rect_h_r;
  logic [7:0]         entry_idx_r;

  logic [12:0]   scr_w_r, scr_h_r;
  logic          full_r, full_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rdv_r, rdv_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          redraw_r, redraw_nxt;
  logic          pend_ent_r, pend_ent_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_tdata_r, out_tdata_nxt;
  logic          out_load;

  logic [49:0]   mem [MAX_RECTS];
  logic [49:0]   rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;

  // Clip and overlap arithmetic
  logic [12:0]        sw, sh;
  logic signed [17:0] sw_s, sh_s;
  logic signed [17:0] ax, ay, aw, ah, ax_end, ay_end;
  logic signed [17:0] cx0, cy0, cx1, cy1, cw_d, ch_d;
  logic               q_empty, c_empty;
  logic [49:0]        clip_ent;
  logic [11:0]        bx, by;
  logic [12:0]        bw, bh;
  logic signed [17:0] bx_s, by_s, bx_end, by_end;
  logic               touch;
  logic [XW-1:0]      count_ext, idx_ext;
  logic               in_range;
  logic [11:0]        ex, ey;
  logic [12:0]        ew, eh;

  assign in_tready  = (state_r == drt_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  assign sw   = (scr_w_r > LIMIT_C) ? LIMIT_C : scr_w_r;
  assign sh   = (scr_h_r > LIMIT_C) ? LIMIT_C : scr_h_r;
  assign sw_s = $signed({5'd0, sw});
  assign sh_s = $signed({5'd0, sh});

  assign ax     = 18'(rect_x_r);
  assign ay     = 18'(rect_y_r);
  assign aw     = 18'(rect_w_r);
  assign ah     = 18'(rect_h_r);
  assign ax_end = ax + aw;
  assign ay_end = ay + ah;

  assign q_empty  = (aw <= 18'sd0) || (ah <= 18'sd0);
  assign cx0      = (ax < 18'sd0) ? 18'sd0 : ax;
  assign cy0      = (ay < 18'sd0) ? 18'sd0 : ay;
  assign cx1      = (ax_end > sw_s) ? sw_s : ax_end;
  assign cy1      = (ay_end > sh_s) ? sh_s : ay_end;
  assign c_empty  = q_empty || (cx1 <= cx0) || (cy1 <= cy0);
  assign cw_d     = cx1 - cx0;
  assign ch_d     = cy1 - cy0;
  assign clip_ent = {ch_d[12:0], cw_d[12:0], cy0[11:0], cx0[11:0]};

  assign bx     = rd_data_r[11:0];
  assign by     = rd_data_r[23:12];
  assign bw     = rd_data_r[36:24];
  assign bh     = rd_data_r[49:37];
  assign bx_s   = $signed({6'd0, bx});
  assign by_s   = $signed({6'd0, by});
  assign bx_end = bx_s + $signed({5'd0, bw});
  assign by_end = by_s + $signed({5'd0, bh});
  assign touch  = !q_empty && (bw != 13'd0) && (bh != 13'd0) &&
                  (ax_end > bx_s) && (bx_end > ax) &&
                  (ay_end > by_s) && (by_end > ay);

  assign count_ext = XW'(count_r);
  assign idx_ext   = XW'(entry_idx_r);
  assign in_range  = idx_ext < count_ext;

  // Entry fields read as zero unless a read found a stored slot
  assign ex = pend_ent_r ? bx : 12'd0;
  assign ey = pend_ent_r ? by : 12'd0;
  assign ew = pend_ent_r ? bw : 13'd0;
  assign eh = pend_ent_r ? bh : 13'd0;

  assign out_tdata_nxt = {1'b0, eh, ew, ey, ex, count_ext[7:0],
                          (full_r || (count_r != '0)), full_r, redraw_r, status_r};

  always_comb begin
    state_nxt     = state_r;
    full_nxt      = full_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rdv_nxt       = 1'b0;
    status_nxt    = status_r;
    redraw_nxt    = redraw_r;
    pend_ent_nxt  = pend_ent_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    unique case (state_r)
      drt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = drt_pkg::S_EXEC;
        end
      end
      drt_pkg::S_EXEC: begin
        status_nxt   = drt_pkg::ST_STORED;
        redraw_nxt   = 1'b0;
        pend_ent_nxt = 1'b0;
        state_nxt    = drt_pkg::S_EMIT;
        case (kind_r)
          drt_pkg::KIND_MARK: begin
            if (full_r) begin
              status_nxt = drt_pkg::ST_IGNORED;
            end else if (c_empty) begin
              status_nxt = drt_pkg::ST_EMPTY;
            end else if (count_r >= MAX_C) begin
              full_nxt   = 1'b1;
              count_nxt  = '0;
              status_nxt = drt_pkg::ST_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end
          drt_pkg::KIND_QUERY: begin
            if (full_r) begin
              redraw_nxt = 1'b1;
            end else if ((count_r != '0) && !q_empty) begin
              state_nxt = drt_pkg::S_QUERY;
              ptr_nxt   = '0;
            end
          end
          drt_pkg::KIND_FULL: begin
            full_nxt  = 1'b1;
            count_nxt = '0;
          end
          drt_pkg::KIND_CLEAR: begin
            full_nxt  = 1'b0;
            count_nxt = '0;
          end
          drt_pkg::KIND_READ: begin
            if (in_range) begin
              mem_re       = 1'b1;
              mem_addr     = idx_ext[AW-1:0];
              pend_ent_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      drt_pkg::S_QUERY: begin
        // Issue one read a cycle; compare the entry read in the previous cycle
        if (rdv_r && touch) begin
          redraw_nxt = 1'b1;
          state_nxt  = drt_pkg::S_EMIT;
        end else if (ptr_r < count_r) begin
          mem_re   = 1'b1;
          mem_addr = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
          rdv_nxt  = 1'b1;
        end else if (!rdv_r) begin
          state_nxt = drt_pkg::S_EMIT;
        end
      end
      drt_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = drt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = drt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drt_pkg::S_IDLE;
      full_r      <= 1'b1;
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      scr_w_r     <= drt_pkg::SCREEN_W_RST;
      scr_h_r     <= drt_pkg::SCREEN_H_RST;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      count_r     <= count_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          drt_pkg::CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
          drt_pkg::CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    status_r   <= status_nxt;
    redraw_r   <= redraw_nxt;
    pend_ent_r <= pend_ent_nxt;
    if (in_tvalid && in_tready) begin
      kind_r      <= drt_pkg::kind_t'(in_tuser[2:0]);
      rect_x_r    <= in_tdata[15:0];
      rect_y_r    <= in_tdata[31:16];
      rect_w_r    <= in_tdata[47:32];
      rect_h_r    <= in_tdata[63:48];
      entry_idx_r <= in_tdata[71:64];
    end
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  // Rectangle table: one port, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= clip_ent;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

`ifndef SYNTH
  a_full_no_rects: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (count_r == '0))
    else $error("full-dirty flag set while rectangles are stored");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("rectangle count above table depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == drt_pkg::S_EXEC))
    else $error("accepted beat not executed");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == drt_pkg::S_EMIT))
    else $error("result raised outside emit state");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == drt_pkg::S_EXEC) && (count_r < MAX_C) && !mem_re))
    else $error("table write out of place");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the dirty rectangle tracker: random commands against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_PHASES     = 8;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        redraw;
    logic        full;
    logic        has;
    logic [7:0]  count;
    logic [11:0] ex;
    logic [11:0] ey;
    logic [12:0] ew;
    logic [12:0] eh;
  } tracker_result_t;

  // Predicts each result from its own copy of the table, flags and screen size,
  // and compares result beats in order against what it predicted.
  class rect_tracker_check;
    box_t            boxes[drt_pkg::MAX_RECTS_DEF];
    int              count;
    bit              full;
    logic [12:0]     sw;
    logic [12:0]     sh;
    tracker_result_t pending_results[$];
    int errors, n_checked, n_stored, n_overflow, n_hits, n_reads;

    function new();
      count = 0;
      full  = 1'b1;
      sw    = drt_pkg::SCREEN_W_RST;
      sh    = drt_pkg::SCREEN_H_RST;
    endfunction

    function void set_reg(logic [0:0] idx, logic [12:0] value);
      if (idx == drt_pkg::CFG_SCREEN_WIDTH) sw = value;
      else sh = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit clip_rect(int x, int y, int w, int h, output box_t o);
      int sw_eff, sh_eff, x0, y0, x1, y1;
      sw_eff = (sw > 13'd4096) ? drt_pkg::SCREEN_LIMIT : int'(sw);
      sh_eff = (sh > 13'd4096) ? drt_pkg::SCREEN_LIMIT : int'(sh);
      o = '{0, 0, 0, 0};
      if (w <= 0 || h <= 0) return 1'b0;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = x + w;
      y1 = y + h;
      if (x1 > sw_eff) x1 = sw_eff;
      if (y1 > sh_eff) y1 = sh_eff;
      if (x1 <= x0 || y1 <= y0) return 1'b0;
      o = '{x0, y0, x1 - x0, y1 - y0};
      return 1'b1;
    endfunction

    function bit rects_touch(int ax, int ay, int aw, int ah, box_t b);
      if (aw <= 0 || ah <= 0 || b.w <= 0 || b.h <= 0) return 1'b0;
      if (ax + aw <= b.x || b.x + b.w <= ax) return 1'b0;
      if (ay + ah <= b.y || b.y + b.h <= ay) return 1'b0;
      return 1'b1;
    endfunction

    function void accept_command(logic [2:0] kind, logic signed [15:0] x,
                                 logic signed [15:0] y, logic signed [15:0] w,
                                 logic signed [15:0] h, logic [7:0] idx);
      tracker_result_t r;
      box_t c;
      int ix, iy, iw, ih;
      r  = '0;
      ix = x;
      iy = y;
      iw = w;
      ih = h;
      case (kind)
        drt_pkg::KIND_MARK: begin
          if (full) begin
            r.status = drt_pkg::ST_IGNORED;
          end else if (!clip_rect(ix, iy, iw, ih, c)) begin
            r.status = drt_pkg::ST_EMPTY;
          end else if (count >= drt_pkg::MAX_RECTS_DEF) begin
            full       = 1'b1;
            count      = 0;
            r.status   = drt_pkg::ST_OVERFLOW;
            n_overflow++;
          end else begin
            boxes[count] = c;
            count++;
            n_stored++;
          end
        end
        drt_pkg::KIND_QUERY: begin
          if (full) begin
            r.redraw = 1'b1;
          end else begin
            for (int i = 0; i < count; i++) begin
              if (rects_touch(ix, iy, iw, ih, boxes[i])) begin
                r.redraw = 1'b1;
                break;
              end
            end
          end
          if (r.redraw) n_hits++;
        end
        drt_pkg::KIND_FULL: begin
          full  = 1'b1;
          count = 0;
        end
        drt_pkg::KIND_CLEAR: begin
          full  = 1'b0;
          count = 0;
        end
        drt_pkg::KIND_READ: begin
          if (int'(idx) < count) begin
            r.ex = boxes[idx].x[11:0];
            r.ey = boxes[idx].y[11:0];
            r.ew = boxes[idx].w[12:0];
            r.eh = boxes[idx].h[12:0];
            n_reads++;
          end
        end
        default: ;
      endcase
      r.full  = full;
      r.has   = full || (count > 0);
      r.count = count[7:0];
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
      if (errors == MAX_PRINTS) $display("ERROR: further mismatch lines suppressed");
    endtask

    task compare_beat(logic [63:0] d);
      tracker_result_t e, g;
      string diffs;
      g.status = d[1:0];
      g.redraw = d[2];
      g.full   = d[3];
      g.has    = d[4];
      g.count  = d[12:5];
      g.ex     = d[24:13];
      g.ey     = d[36:25];
      g.ew     = d[49:37];
      g.eh     = d[62:50];
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h arrived with nothing predicted", d));
        return;
      end
      e = pending_results.pop_front();
      n_checked++;
      diffs = "";
      if (g.status != e.status) diffs = {diffs, $sformatf(" status %0d/%0d", g.status, e.status)};
      if (g.redraw != e.redraw) diffs = {diffs, $sformatf(" redraw %0d/%0d", g.redraw, e.redraw)};
      if (g.full != e.full) diffs = {diffs, $sformatf(" full %0d/%0d", g.full, e.full)};
      if (g.has != e.has) diffs = {diffs, $sformatf(" has %0d/%0d", g.has, e.has)};
      if (g.count != e.count) diffs = {diffs, $sformatf(" count %0d/%0d", g.count, e.count)};
      if (g.ex != e.ex) diffs = {diffs, $sformatf(" x %0d/%0d", g.ex, e.ex)};
      if (g.ey != e.ey) diffs = {diffs, $sformatf(" y %0d/%0d", g.ey, e.ey)};
      if (g.ew != e.ew) diffs = {diffs, $sformatf(" w %0d/%0d", g.ew, e.ew)};
      if (g.eh != e.eh) diffs = {diffs, $sformatf(" h %0d/%0d", g.eh, e.eh)};
      if (diffs != "") report($sformatf("result %0d (got/exp):%s", n_checked, diffs));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [12:0] cfg_wdata;

  rect_tracker_check sb = new;
  int cycles;
  int n_sent;
  int burst_left;
  bit nogap;
  int hold_requests;

  dirty_rect_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.compare_beat(out_tdata);
  end

  // Receiver: random stall patterns, plus a long hold-off on request.
  initial begin
    int mode, mode_left, hold_left, served;
    out_tready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] w,
                           input logic signed [15:0] h, input logic [7:0] idx);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {idx, h, w, y, x};
    do @(posedge clk); while (!in_tready);
    sb.accept_command(kind, x, y, w, h, idx);
    n_sent++;
  endtask

  // Send in bursts; unless nogap is set, drop valid for a random gap between bursts.
  task automatic offer(input logic [2:0] kind, input logic signed [15:0] x,
                       input logic signed [15:0] y, input logic signed [15:0] w,
                       input logic signed [15:0] h, input logic [7:0] idx);
    if (burst_left == 0) begin
      if (!nogap) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(kind, x, y, w, h, idx);
  endtask

  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_rect(output logic signed [15:0] x, output logic signed [15:0] y,
                           output logic signed [15:0] w, output logic signed [15:0] h);
    int sw_eff, sh_eff, r;
    sw_eff = (sb.sw > 13'd4096) ? drt_pkg::SCREEN_LIMIT : int'(sb.sw);
    sh_eff = (sb.sh > 13'd4096) ? drt_pkg::SCREEN_LIMIT : int'(sb.sh);
    if (sw_eff == 0) sw_eff = 1;
    if (sh_eff == 0) sh_eff = 1;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      // mostly on screen, some hanging over the left or top edge
      x = 16'($urandom_range(0, sw_eff + 8) - 8);
      y = 16'($urandom_range(0, sh_eff + 8) - 8);
      w = 16'($urandom_range(1, sw_eff / 4 + 1));
      h = 16'($urandom_range(1, sh_eff / 4 + 1));
    end else if (r < 90) begin
      x = 16'($urandom);
      y = 16'($urandom);
      w = 16'($urandom);
      h = 16'($urandom);
    end else begin
      x = 16'($urandom_range(0, sw_eff));
      y = 16'($urandom_range(0, sh_eff));
      w = 16'(0) - 16'($urandom_range(0, 3));
      h = 16'($urandom_range(1, 8));
      if (r[0]) begin
        h = w;
        w = 16'($urandom_range(1, 8));
      end
    end
  endtask

  task automatic random_item(input bit episode_start);
    logic [2:0] kind;
    logic signed [15:0] x, y, w, h;
    logic [7:0] idx;
    int r;
    pick_rect(x, y, w, h);
    idx = 8'($urandom_range(0, 255));
    r   = $urandom_range(0, 999);
    if (episode_start) begin
      // open most runs from an empty table so marks can fill it
      if (r < 800) kind = drt_pkg::KIND_CLEAR;
      else if (r < 900) kind = drt_pkg::KIND_FULL;
      else kind = drt_pkg::KIND_MARK;
    end else if (r < 640) begin
      kind = drt_pkg::KIND_MARK;
    end else if (r < 840) begin
      kind = drt_pkg::KIND_QUERY;
    end else if (r < 980) begin
      kind = drt_pkg::KIND_READ;
      if (sb.count > 0 && $urandom_range(0, 9) < 7) begin
        idx = 8'($urandom_range(0, sb.count - 1));
      end
    end else if (r < 984) begin
      kind = drt_pkg::KIND_FULL;
    end else if (r < 988) begin
      kind = drt_pkg::KIND_CLEAR;
    end else begin
      kind = 3'($urandom_range(5, 7));
    end
    offer(kind, x, y, w, h, idx);
  endtask

  task automatic run_phase(input int n_items);
    int run_left;
    run_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(20, 400);
        random_item(1'b1);
      end else begin
        random_item(1'b0);
      end
      run_left--;
    end
  endtask

  task automatic directed();
    send_item(drt_pkg::KIND_QUERY, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd10, 16'sd10, 16'sd5, 16'sd5, 8'd0);
    send_item(drt_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    send_item(3'd5, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 8'hff);
    send_item(drt_pkg::KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    send_item(drt_pkg::KIND_QUERY, 16'sd0, 16'sd0, 16'sd640, 16'sd480, 8'd0);
    send_item(drt_pkg::KIND_MARK, -16'sd20, -16'sd20, 16'sd50, 16'sd40, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd600, 16'sd470, 16'sd32767, 16'sd32767, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd700, 16'sd10, 16'sd10, 16'sd10, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd10, 16'sd10, -16'sd32768, 16'sd5, 8'd0);
    send_item(drt_pkg::KIND_MARK, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 8'd0);
    send_item(drt_pkg::KIND_QUERY, 16'sd639, 16'sd479, 16'sd1, 16'sd1, 8'd0);
    send_item(drt_pkg::KIND_QUERY, 16'sd5, 16'sd5, 16'sd0, 16'sd5, 8'd0);
    send_item(drt_pkg::KIND_QUERY, 16'sd5, 16'sd5, 16'sd5, -16'sd1, 8'd0);
    send_item(drt_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    send_item(drt_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd2);
    send_item(drt_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd3);
    send_item(drt_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd255);
    send_item(3'd6, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 8'd0);
    send_item(3'd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd1);
    send_item(drt_pkg::KIND_FULL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    send_item(drt_pkg::KIND_MARK, 16'sd1, 16'sd1, 16'sd8, 16'sd8, 8'd0);
    send_item(drt_pkg::KIND_QUERY, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 8'd0);
    send_item(drt_pkg::KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0);
  endtask

  initial begin
    int widths[N_PHASES];
    int heights[N_PHASES];
    widths  = '{640, 1, 4096, 0, 8191, 200, 4095, 1000};
    heights = '{480, 1, 4096, 300, 8191, 0, 33, 4097};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    burst_left = 0;
    nogap      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p[0]) begin
        write_cfg(drt_pkg::CFG_SCREEN_HEIGHT, heights[p][12:0]);
        write_cfg(drt_pkg::CFG_SCREEN_WIDTH, widths[p][12:0]);
      end else begin
        write_cfg(drt_pkg::CFG_SCREEN_WIDTH, widths[p][12:0]);
        write_cfg(drt_pkg::CFG_SCREEN_HEIGHT, heights[p][12:0]);
      end
      // keep offering back to back while the receiver holds off
      nogap = (p == 2);
      if (p == 2) hold_requests++;
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (drt_pkg::MAX_RECTS_DEF + 16) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d predicted results never came", sb.pending()));
    $display("ran %0d commands over %0d screen settings, %0d results checked",
             n_sent, N_PHASES + 1, sb.n_checked);
    $display("stored %0d rects, %0d overflows, %0d query hits, %0d in-range reads",
             sb.n_stored, sb.n_overflow, sb.n_hits, sb.n_reads);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/drt_pkg.sv
sv/dirty_rect_tracker.sv
tb/tb.sv
